[rtl/core/http_request_head_parser_top_defines.svh]
// ----------------------------------------------------------------------------
// HTTP request head parser assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_PARSER_TOP_DEFINES_SVH
`define HTTP_REQUEST_HEAD_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HRHP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define HRHP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HRHP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define HRHP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/core/hrhp_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP request head parser package
// Codes, parser state type and character class functions.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_BAD        = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ROLE_DELIM  = 3'd0,
    ROLE_METHOD = 3'd1,
    ROLE_URI    = 3'd2,
    ROLE_NAME   = 3'd3,
    ROLE_VALUE  = 3'd4
  } role_t;

  typedef enum logic [4:0] {
    PH_START     = 5'd0,
    PH_METHOD    = 5'd1,
    PH_URI       = 5'd2,
    PH_H         = 5'd3,
    PH_T1        = 5'd4,
    PH_T2        = 5'd5,
    PH_P         = 5'd6,
    PH_SLASH     = 5'd7,
    PH_MAJ_FIRST = 5'd8,
    PH_MAJ       = 5'd9,
    PH_MIN_FIRST = 5'd10,
    PH_MIN       = 5'd11,
    PH_LF_LINE   = 5'd12,
    PH_HDR_START = 5'd13,
    PH_FOLD      = 5'd14,
    PH_NAME      = 5'd15,
    PH_SPACE     = 5'd16,
    PH_VALUE     = 5'd17,
    PH_LF_HDR    = 5'd18,
    PH_LF_END    = 5'd19
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    status_t    sticky;
    logic       header_seen;
    logic [7:0] major;
    logic [7:0] minor;
  } parser_state_t;

  localparam parser_state_t STATE_RESET = '{
    phase:       PH_START,
    sticky:      ST_INCOMPLETE,
    header_seen: 1'b0,
    major:       8'd0,
    minor:       8'd0
  };

  localparam logic [7:0]  CH_TAB      = 8'h09;
  localparam logic [7:0]  CH_LF       = 8'h0A;
  localparam logic [7:0]  CH_CR       = 8'h0D;
  localparam logic [7:0]  CH_SP       = 8'h20;
  localparam logic [7:0]  CH_DOT      = 8'h2E;
  localparam logic [7:0]  CH_SLASH    = 8'h2F;
  localparam logic [7:0]  CH_ZERO     = 8'h30;
  localparam logic [7:0]  CH_NINE     = 8'h39;
  localparam logic [7:0]  CH_COLON    = 8'h3A;
  localparam logic [7:0]  CH_H        = 8'h48;
  localparam logic [7:0]  CH_P        = 8'h50;
  localparam logic [7:0]  CH_T        = 8'h54;
  localparam logic [7:0]  CH_DEL      = 8'h7F;
  localparam logic [7:0]  CTRL_LIMIT  = 8'h20;
  localparam logic [11:0] VERSION_CAP = 12'd255;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_ctrl(logic [7:0] c);
    return c < CTRL_LIMIT || c == CH_DEL;
  endfunction

  function automatic logic is_separator(logic [7:0] c);
    logic sep;
    case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return sep;
  endfunction

  function automatic logic is_token(logic [7:0] c);
    return !c[7] && !is_ctrl(c) && !is_separator(c);
  endfunction

  // v * 10 + digit, clamped at the version cap
  function automatic logic [7:0] add_digit(logic [7:0] v, logic [7:0] c);
    logic [7:0]  d;
    logic [11:0] n;
    d = c - CH_ZERO;
    n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {4'd0, d};
    return (n > VERSION_CAP) ? VERSION_CAP[7:0] : n[7:0];
  endfunction

endpackage

[rtl/core/hrhp_in_if.sv]
// ----------------------------------------------------------------------------
// HTTP request head parser byte channel
// Valid/ready channel carrying one head byte and a restart flag.
// ----------------------------------------------------------------------------
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

[rtl/core/hrhp_out_if.sv]
// ----------------------------------------------------------------------------
// HTTP request head parser result channel
// Valid/ready channel carrying the per-byte verdict and versions.
// ----------------------------------------------------------------------------
interface hrhp_out_if;
  logic              valid;
  logic              ready;
  hrhp_pkg::status_t status;
  hrhp_pkg::role_t   byte_role;
  logic              header_start;
  logic [7:0]        major_version;
  logic [7:0]        minor_version;

  modport source (output valid, output status, output byte_role, output header_start,
                  output major_version, output minor_version, input ready);
  modport sink (input valid, input status, input byte_role, input header_start,
                input major_version, input minor_version, output ready);
endinterface

[rtl/core/hrhp_step.sv]
// ----------------------------------------------------------------------------
// HTTP request head parser byte step
// Phase transition and character checks for one byte of the head.
// ----------------------------------------------------------------------------
module hrhp_step (
  input  hrhp_pkg::parser_state_t cur,
  input  logic [7:0]              data_byte,
  input  logic                    restart,
  output hrhp_pkg::parser_state_t nxt,
  output hrhp_pkg::status_t       status,
  output hrhp_pkg::role_t         byte_role,
  output logic                    header_start
);
  import hrhp_pkg::*;

  parser_state_t base;
  status_t       st;
  role_t         role;
  logic          hs;
  logic          blank;

  assign blank = (data_byte == CH_SP) || (data_byte == CH_TAB);

  always_comb begin
    base = restart ? STATE_RESET : cur;
    nxt  = base;
    st   = ST_INCOMPLETE;
    role = ROLE_DELIM;
    hs   = 1'b0;
    if (base.sticky != ST_INCOMPLETE) begin
      // hold everything once finished
      st = base.sticky;
    end else begin
      case (base.phase)
        PH_START: begin
          if (!is_alpha(data_byte)) st = ST_BAD;
          else begin
            nxt.phase = PH_METHOD;
            role      = ROLE_METHOD;
          end
        end
        PH_METHOD: begin
          if (data_byte == CH_SP) nxt.phase = PH_URI;
          else if (!is_alpha(data_byte)) st = ST_BAD;
          else role = ROLE_METHOD;
        end
        PH_URI: begin
          if (data_byte == CH_SP) nxt.phase = PH_H;
          else if (is_ctrl(data_byte)) st = ST_BAD;
          else role = ROLE_URI;
        end
        PH_H: begin
          if (data_byte != CH_H) st = ST_BAD;
          else nxt.phase = PH_T1;
        end
        PH_T1: begin
          if (data_byte != CH_T) st = ST_BAD;
          else nxt.phase = PH_T2;
        end
        PH_T2: begin
          if (data_byte != CH_T) st = ST_BAD;
          else nxt.phase = PH_P;
        end
        PH_P: begin
          if (data_byte != CH_P) st = ST_BAD;
          else nxt.phase = PH_SLASH;
        end
        PH_SLASH: begin
          if (data_byte != CH_SLASH) st = ST_BAD;
          else begin
            nxt.major = 8'd0;
            nxt.minor = 8'd0;
            nxt.phase = PH_MAJ_FIRST;
          end
        end
        PH_MAJ_FIRST: begin
          if (!is_digit(data_byte)) st = ST_BAD;
          else begin
            nxt.major = add_digit(base.major, data_byte);
            nxt.phase = PH_MAJ;
          end
        end
        PH_MAJ: begin
          if (data_byte == CH_DOT) nxt.phase = PH_MIN_FIRST;
          else if (!is_digit(data_byte)) st = ST_BAD;
          else nxt.major = add_digit(base.major, data_byte);
        end
        PH_MIN_FIRST: begin
          if (!is_digit(data_byte)) st = ST_BAD;
          else begin
            nxt.minor = add_digit(base.minor, data_byte);
            nxt.phase = PH_MIN;
          end
        end
        PH_MIN: begin
          if (data_byte == CH_CR) nxt.phase = PH_LF_LINE;
          else if (!is_digit(data_byte)) st = ST_BAD;
          else nxt.minor = add_digit(base.minor, data_byte);
        end
        PH_LF_LINE: begin
          if (data_byte != CH_LF) st = ST_BAD;
          else nxt.phase = PH_HDR_START;
        end
        PH_HDR_START: begin
          if (data_byte == CH_CR) nxt.phase = PH_LF_END;
          else if (base.header_seen && blank) nxt.phase = PH_FOLD;
          else if (!is_token(data_byte)) st = ST_BAD;
          else begin
            nxt.header_seen = 1'b1;
            role            = ROLE_NAME;
            hs              = 1'b1;
            nxt.phase       = PH_NAME;
          end
        end
        PH_FOLD: begin
          // skip leading blanks of a continuation line
          if (data_byte == CH_CR) nxt.phase = PH_LF_HDR;
          else if (blank) nxt.phase = PH_FOLD;
          else if (is_ctrl(data_byte)) st = ST_BAD;
          else begin
            role      = ROLE_VALUE;
            nxt.phase = PH_VALUE;
          end
        end
        PH_NAME: begin
          if (data_byte == CH_COLON) nxt.phase = PH_SPACE;
          else if (!is_token(data_byte)) st = ST_BAD;
          else role = ROLE_NAME;
        end
        PH_SPACE: begin
          if (data_byte != CH_SP) st = ST_BAD;
          else nxt.phase = PH_VALUE;
        end
        PH_VALUE: begin
          if (data_byte == CH_CR) nxt.phase = PH_LF_HDR;
          else if (is_ctrl(data_byte)) st = ST_BAD;
          else role = ROLE_VALUE;
        end
        PH_LF_HDR: begin
          if (data_byte != CH_LF) st = ST_BAD;
          else nxt.phase = PH_HDR_START;
        end
        PH_LF_END: begin
          if (data_byte != CH_LF) st = ST_BAD;
          else st = ST_COMPLETE;
        end
        default: st = ST_BAD;
      endcase
      if (st == ST_BAD) begin
        role = ROLE_DELIM;
        hs   = 1'b0;
      end
      nxt.sticky = st;
    end
  end

  assign status       = st;
  assign byte_role    = role;
  assign header_start = hs;

endmodule

[rtl/core/http_request_head_parser_top.sv]
// ----------------------------------------------------------------------------
// HTTP request head parser
// Byte-serial checker of an HTTP request line and header block.
// ----------------------------------------------------------------------------
// The parser takes one byte of a request head per clock while results
// are taken, and returns one result per byte: status, role of the byte,
// a new-header flag and the version numbers seen so far. Sustained rate
// is one byte per cycle without back-pressure; the limit is the update
// of the parser state register, which holds the phase, the sticky status
// and the version counts. A byte passes through the input register, then
// the result register, and the input side keeps accepting while a result
// waits to be taken, as long as the input register is free to move on.
`include "http_request_head_parser_top_defines.svh"

module http_request_head_parser_top (
  input logic        clk,
  input logic        rst,
  hrhp_in_if.sink    bytes,
  hrhp_out_if.source results
);
  import hrhp_pkg::*;

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_restart;
  logic          o_valid;
  logic          adv;
  parser_state_t state;
  parser_state_t state_next;
  status_t       step_status;
  role_t         step_role;
  logic          step_hs;
  status_t       o_status;
  role_t         o_role;
  logic          o_hs;
  logic [7:0]    o_major;
  logic [7:0]    o_minor;

  // move the held byte into the result register when that slot frees up
  assign adv          = s1_valid && (!o_valid || results.ready);
  assign bytes.ready  = !s1_valid || adv;

  hrhp_step u_step (
    .cur          (state),
    .data_byte    (s1_byte),
    .restart      (s1_restart),
    .nxt          (state_next),
    .status       (step_status),
    .byte_role    (step_role),
    .header_start (step_hs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
      state    <= STATE_RESET;
    end else begin
      if (bytes.ready) s1_valid <= bytes.valid;
      if (adv) begin
        state   <= state_next;
        o_valid <= 1'b1;
      end else if (results.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_byte    <= bytes.data_byte;
      s1_restart <= bytes.restart;
    end
    if (adv) begin
      o_status <= step_status;
      o_role   <= step_role;
      o_hs     <= step_hs;
      o_major  <= state_next.major;
      o_minor  <= state_next.minor;
    end
  end

  assign results.valid         = o_valid;
  assign results.status        = o_status;
  assign results.byte_role     = o_role;
  assign results.header_start  = o_hs;
  assign results.major_version = o_major;
  assign results.minor_version = o_minor;

  `HRHP_ASSERT_IMP(a_bad_no_role, clk, rst, o_valid && o_status == ST_BAD, o_role == ROLE_DELIM && !o_hs, "bad byte carries a role")
  `HRHP_ASSERT_IMP(a_start_is_name, clk, rst, o_valid && o_hs, o_role == ROLE_NAME && o_status == ST_INCOMPLETE, "header start outside a name")
  `HRHP_ASSERT_NXT(a_sticky_holds, clk, rst, state.sticky != ST_INCOMPLETE && !(adv && s1_restart), state.sticky == $past(state.sticky), "finished status changed without restart")
  `HRHP_ASSERT_NXT(a_state_idle, clk, rst, !adv, $stable(state), "parser state moved without a byte")
  `HRHP_ASSERT_NXT(a_hold_byte, clk, rst, s1_valid && !adv, s1_valid && $stable(s1_byte), "held byte lost")

endmodule
